// ----- rtl/core/preemptive_priority_scheduler_assert.svh -----
// Assertion macros used by the scheduler RTL.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("scheduler assertion failed");
`define PPS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scheduler reset assertion failed");
`else
`define PPS_ASSERT(lbl, clk, rstn, prop)
`define PPS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ----- rtl/core/pps_pkg.sv -----
// Types and constants shared by the scheduler modules.
`default_nettype none
package pps_pkg;

  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned ARR_W    = 16;
  localparam int unsigned BURST_W  = 16;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned TIME_W   = 20;
  localparam int unsigned PCOUNT_W = 5;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Register index, taken from the word address bits of paddr.
  localparam logic [PADDR_W-3:0] REG_PROC_COUNT = '0;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] remaining;
  } pps_entry_t;

  localparam int unsigned ENTRY_W = $bits(pps_entry_t);

  typedef struct packed {
    logic any_work;
    logic found;
  } pps_sel_t;

endpackage
`default_nettype wire

// ----- rtl/core/pps_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module pps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/pps_cfg.sv -----
// APB register block holding the number of slots in use.
`default_nettype none
module pps_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pps_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [pps_pkg::PDATA_W-1:0]  pwdata,
  output logic      [pps_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output logic      [pps_pkg::PCOUNT_W-1:0] proc_count_o
);
  import pps_pkg::*;

  logic [PCOUNT_W-1:0] pcount_q, pcount_d;
  logic                sel_count;

  assign sel_count = (paddr[PADDR_W-1:2] == REG_PROC_COUNT);

  always_comb begin
    pcount_d = pcount_q;
    if (psel && penable && pwrite && sel_count) begin
      pcount_d = pwdata[PCOUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= '0;
    end else begin
      pcount_q <= pcount_d;
    end
  end

  assign prdata       = sel_count ? {{(PDATA_W-PCOUNT_W){1'b0}}, pcount_q} : '0;
  assign pready       = 1'b1;
  assign proc_count_o = pcount_q;

endmodule
`default_nettype wire

// ----- rtl/core/pps_sel.sv -----
// Running best-candidate selector fed with one table entry per cycle while eval_i is high.
`default_nettype none
module pps_sel #(
  parameter int unsigned IDX_W = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clear_i,
  input  wire logic                        eval_i,
  input  wire logic [IDX_W-1:0]            idx_i,
  input  wire pps_pkg::pps_entry_t         entry_i,
  input  wire logic [pps_pkg::TIME_W-1:0]  time_i,
  output pps_pkg::pps_sel_t                status_o,
  output logic      [IDX_W-1:0]            best_idx_o,
  output pps_pkg::pps_entry_t              best_o
);
  import pps_pkg::*;

  pps_sel_t   st_q, st_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  pps_entry_t best_q, best_d;
  logic       has_work, arrived, better;

  assign has_work = (entry_i.remaining != '0);
  assign arrived  = ({{(TIME_W-ARR_W){1'b0}}, entry_i.arrival} <= time_i);
  // Lower priority number wins; equal priority falls to the earlier arrival.
  // A later slot never displaces an earlier one on a full tie.
  assign better   = !st_q.found || (entry_i.prio < best_q.prio) ||
                    ((entry_i.prio == best_q.prio) && (entry_i.arrival < best_q.arrival));

  always_comb begin
    st_d   = st_q;
    idx_d  = idx_q;
    best_d = best_q;
    if (clear_i) begin
      st_d = '0;
    end else if (eval_i && has_work) begin
      st_d.any_work = 1'b1;
      if (arrived && better) begin
        st_d.found = 1'b1;
        idx_d      = idx_i;
        best_d     = entry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    best_q <= best_d;
  end

  assign status_o   = st_q;
  assign best_idx_o = idx_q;
  assign best_o     = best_q;

endmodule
`default_nettype wire

// ----- rtl/core/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler: slot table in RAM, scanned once per tick.
// A load transaction is accepted in the idle state and writes its slot directly.
// A tick reads n = min(proc_count, SLOTS) slots from RAM, one read per slot, then
// passes an update state and a report state; no new input is taken until it is done.
// Reset clears the per-slot valid flags, time, last selection and proc_count;
// a slot never loaded reads as zero, so no clearing pass is needed.
`default_nettype none
`include "preemptive_priority_scheduler_assert.svh"
module preemptive_priority_scheduler #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pps_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [pps_pkg::PDATA_W-1:0]  pwdata,
  output logic      [pps_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         kind_i,
  input  wire logic [pps_pkg::SLOT_W-1:0]   slot_i,
  input  wire logic [pps_pkg::ARR_W-1:0]    arrival_i,
  input  wire logic [pps_pkg::BURST_W-1:0]  burst_i,
  input  wire logic [pps_pkg::PRIO_W-1:0]   priority_req_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [pps_pkg::SLOT_W-1:0]   running_slot_o,
  output logic                              idle_o,
  output logic                              switched_o,
  output logic                              first_run_o,
  output logic                              finished_o,
  output logic                              all_done_o,
  output logic      [pps_pkg::TIME_W-1:0]   tick_time_o,
  output logic      [pps_pkg::TIME_W-1:0]   turnaround_o,
  output logic      [pps_pkg::TIME_W-1:0]   waiting_o
);
  import pps_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [7:0]  SLOTS8 = 8'(SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN1 = 2'd2;
  localparam logic [1:0] ST_FIN2 = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    rd_cnt_q, rd_cnt_d, n_q, n_d;
  logic                rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]    ev_idx_q, ev_idx_d;
  logic [SLOTS-1:0]    vld_q, vld_d;
  logic [TIME_W-1:0]   time_q, time_d, time_inc;
  logic                last_vld_q, last_vld_d;
  logic [IDX_W-1:0]    last_idx_q, last_idx_d;

  // Partial result held between the update cycle and the output register.
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic                res_idle_q, res_idle_d, res_sw_q, res_sw_d;
  logic                res_first_q, res_first_d, res_fin_q, res_fin_d;
  logic                res_all_q, res_all_d;
  logic [TIME_W-1:0]   res_time_q, res_time_d, res_ta_q, res_ta_d;

  logic                out_vld_q, out_vld_d, out_load;
  logic [SLOT_W-1:0]   o_slot_q;
  logic                o_idle_q, o_sw_q, o_first_q, o_fin_q, o_all_q;
  logic [TIME_W-1:0]   o_time_q, o_ta_q, o_wait_q, wait_val;

  logic [PCOUNT_W-1:0] proc_count;
  logic [7:0]          pc8, n8, slot_ext, best_ext;
  logic                in_acc, slot_ok;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  pps_entry_t          ram_wdata, ram_rdata, ev_entry, best;
  logic [ENTRY_W-1:0]  ram_rdata_raw;

  logic                sel_clear, sel_eval;
  pps_sel_t            sel_st;
  logic [IDX_W-1:0]    best_idx;

  pps_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .proc_count_o (proc_count)
  );

  pps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = pps_entry_t'(ram_rdata_raw);
  // A slot that was never loaded reads as an empty entry.
  assign ev_entry  = vld_q[ev_idx_q] ? ram_rdata : '0;

  pps_sel #(
    .IDX_W (IDX_W)
  ) u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (sel_clear),
    .eval_i     (sel_eval),
    .idx_i      (ev_idx_q),
    .entry_i    (ev_entry),
    .time_i     (time_q),
    .status_o   (sel_st),
    .best_idx_o (best_idx),
    .best_o     (best)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_ext   = {4'b0, slot_i};
  assign slot_ok    = (slot_ext < SLOTS8);
  assign pc8        = {3'b0, proc_count};
  assign n8         = (pc8 > SLOTS8) ? SLOTS8 : pc8;
  assign best_ext   = {{(8-IDX_W){1'b0}}, best_idx};
  assign time_inc   = (time_q == TIME_MAX) ? time_q : time_q + 1'b1;
  assign sel_eval   = (state_q == ST_SCAN) && rd_pend_q;
  assign wait_val   = (res_fin_q && (res_ta_q > {{(TIME_W-BURST_W){1'b0}}, best.burst}))
                      ? res_ta_q - {{(TIME_W-BURST_W){1'b0}}, best.burst} : '0;
  assign out_load   = (state_q == ST_FIN2) && (!out_vld_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    n_d         = n_q;
    rd_pend_d   = 1'b0;
    ev_idx_d    = ev_idx_q;
    vld_d       = vld_q;
    time_d      = time_q;
    last_vld_d  = last_vld_q;
    last_idx_d  = last_idx_q;
    res_slot_d  = res_slot_q;
    res_idle_d  = res_idle_q;
    res_sw_d    = res_sw_q;
    res_first_d = res_first_q;
    res_fin_d   = res_fin_q;
    res_all_d   = res_all_q;
    res_time_d  = res_time_q;
    res_ta_d    = res_ta_q;
    sel_clear   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = slot_ext[IDX_W-1:0];
    ram_wdata   = '{arrival: arrival_i, burst: burst_i, prio: priority_req_i,
                    remaining: burst_i};
    ram_re      = 1'b0;
    ram_raddr   = rd_cnt_q[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_LOAD) begin
            if (slot_ok) begin
              ram_we                       = 1'b1;
              vld_d[slot_ext[IDX_W-1:0]]   = 1'b1;
            end
          end else begin
            state_d   = ST_SCAN;
            rd_cnt_d  = '0;
            n_d       = n8[CNT_W-1:0];
            sel_clear = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // The data of the last read is judged at the same edge that leaves the scan.
        if (rd_cnt_q == n_q) begin
          state_d = ST_FIN1;
        end else begin
          ram_re    = 1'b1;
          rd_pend_d = 1'b1;
          ev_idx_d  = rd_cnt_q[IDX_W-1:0];
          rd_cnt_d  = rd_cnt_q + 1'b1;
        end
      end
      ST_FIN1: begin
        state_d     = ST_FIN2;
        res_time_d  = time_q;
        res_slot_d  = '0;
        res_idle_d  = 1'b1;
        res_sw_d    = 1'b0;
        res_first_d = 1'b0;
        res_fin_d   = 1'b0;
        res_all_d   = 1'b0;
        res_ta_d    = '0;
        priority if (!sel_st.any_work) begin
          res_all_d = 1'b1;
        end else if (!sel_st.found) begin
          res_sw_d   = last_vld_q;
          last_vld_d = 1'b0;
          last_idx_d = '0;
          time_d     = time_inc;
        end else begin
          res_slot_d  = best_ext[SLOT_W-1:0];
          res_idle_d  = 1'b0;
          res_sw_d    = !last_vld_q || (last_idx_q != best_idx);
          res_first_d = (best.remaining == best.burst);
          res_fin_d   = (best.remaining == BURST_W'(1));
          res_ta_d    = (best.remaining == BURST_W'(1))
                        ? time_inc - {{(TIME_W-ARR_W){1'b0}}, best.arrival} : '0;
          last_vld_d  = 1'b1;
          last_idx_d  = best_idx;
          time_d      = time_inc;
          // The scan is over, so this write cannot meet a read of the same slot.
          ram_we              = 1'b1;
          ram_waddr           = best_idx;
          ram_wdata           = best;
          ram_wdata.remaining = best.remaining - 1'b1;
        end
      end
      ST_FIN2: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_cnt_q   <= '0;
      n_q        <= '0;
      rd_pend_q  <= 1'b0;
      vld_q      <= '0;
      time_q     <= '0;
      last_vld_q <= 1'b0;
      last_idx_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      n_q        <= n_d;
      rd_pend_q  <= rd_pend_d;
      vld_q      <= vld_d;
      time_q     <= time_d;
      last_vld_q <= last_vld_d;
      last_idx_q <= last_idx_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q    <= ev_idx_d;
    res_slot_q  <= res_slot_d;
    res_idle_q  <= res_idle_d;
    res_sw_q    <= res_sw_d;
    res_first_q <= res_first_d;
    res_fin_q   <= res_fin_d;
    res_all_q   <= res_all_d;
    res_time_q  <= res_time_d;
    res_ta_q    <= res_ta_d;
    if (out_load) begin
      o_slot_q  <= res_slot_q;
      o_idle_q  <= res_idle_q;
      o_sw_q    <= res_sw_q;
      o_first_q <= res_first_q;
      o_fin_q   <= res_fin_q;
      o_all_q   <= res_all_q;
      o_time_q  <= res_time_q;
      o_ta_q    <= res_ta_q;
      o_wait_q  <= wait_val;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign running_slot_o = o_slot_q;
  assign idle_o         = o_idle_q;
  assign switched_o     = o_sw_q;
  assign first_run_o    = o_first_q;
  assign finished_o     = o_fin_q;
  assign all_done_o     = o_all_q;
  assign tick_time_o    = o_time_q;
  assign turnaround_o   = o_ta_q;
  assign waiting_o      = o_wait_q;

  `PPS_ASSERT(a_ram_we_phase, clk_i, rst_ni,
              (ram_we |-> (state_q == ST_IDLE || state_q == ST_FIN1)))
  `PPS_ASSERT(a_scan_bound, clk_i, rst_ni, ((state_q == ST_SCAN) |-> (rd_cnt_q <= n_q)))
  `PPS_ASSERT(a_done_time_hold, clk_i, rst_ni,
              ((state_q == ST_FIN1 && !sel_st.any_work) |=> $stable(time_q)))
  `PPS_ASSERT(a_idle_slot_zero, clk_i, rst_ni,
              ((out_valid_o && idle_o) |-> (running_slot_o == '0 && !finished_o)))
  `PPS_ASSERT_RST(a_reset_no_result, clk_i, (!rst_ni |=> (!out_valid_o && !in_stall_o)))

endmodule
`default_nettype wire
